// ===== hw/rtl/rtp_hef_pkg.sv =====
// ----------------------------------------------------------------------------
// RTP header extension finder package
// Transfer types, status codes, parse phases and RTP header constants.
// ----------------------------------------------------------------------------
package rtp_hef_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [11:0] data_offset;
      logic [7:0]  data_length;
   } rsp_type;

   localparam logic [3:0] ST_NOT_FOUND    = 4'd0;
   localparam logic [3:0] ST_FOUND        = 4'd1;
   localparam logic [3:0] ST_ID_ZERO      = 4'd2;
   localparam logic [3:0] ST_SHORT_HDR    = 4'd3;
   localparam logic [3:0] ST_BAD_VERSION  = 4'd4;
   localparam logic [3:0] ST_EXT_HDR_CUT  = 4'd5;
   localparam logic [3:0] ST_PAYLOAD_CUT  = 4'd6;
   localparam logic [3:0] ST_ID15         = 4'd7;
   localparam logic [3:0] ST_ONE_ELEM_CUT = 4'd8;
   localparam logic [3:0] ST_TWO_LEN_CUT  = 4'd9;
   localparam logic [3:0] ST_TWO_ELEM_CUT = 4'd10;
   localparam logic [3:0] ST_TOO_LONG     = 4'd11;

   typedef enum logic [6:0] {
      PH_HEAD     = 7'b0000001,
      PH_ONE_HDR  = 7'b0000010,
      PH_ONE_SKIP = 7'b0000100,
      PH_TWO_ID   = 7'b0001000,
      PH_TWO_LEN  = 7'b0010000,
      PH_TWO_SKIP = 7'b0100000,
      PH_DONE     = 7'b1000000
   } phase_type;

   // payload end reaches 12 + 60 + 4 + 4 * 65535
   localparam int unsigned PEND_W = 19;

   localparam logic [15:0] PROFILE_ONE_BYTE = 16'hBEDE;
   localparam logic [15:0] PROFILE_TWO_MASK = 16'hFFF0;
   localparam logic [15:0] PROFILE_TWO_BYTE = 16'h1000;
   localparam logic [3:0]  ID_RESERVED      = 4'hF;
   localparam logic [1:0]  RTP_VERSION      = 2'd2;
   localparam logic [6:0]  FIXED_HDR_BYTES  = 7'd12;

endpackage

// ===== hw/rtl/rtp_header_extension_finder.sv =====
// ----------------------------------------------------------------------------
// RTP header extension finder
// Parses an RTP packet byte by byte and reports the first header extension
// element (one-byte or two-byte form) carrying the configured id.
// ----------------------------------------------------------------------------
//  channel | ports                               | dir | carries
//  req     | req_valid req_ready req_payload     | in  | packet byte + last flag
//  rsp     | rsp_valid rsp_ready rsp_payload     | out | status, offset, length
//  csr     | csr_valid csr_ready csr_data        | in  | target id
//
//  One byte per cycle while no last byte is held back by a waiting result; a
//  byte is registered in the input register while the parse logic works on it,
//  and the result register is loaded as a last byte leaves that register.
//  One result per packet, loaded on the last byte.
//  Synchronous reset clears the parser and sets the target id to 1.
//  A result waiting in the output register holds back only a following last
//  byte; other bytes keep flowing.
// ----------------------------------------------------------------------------
module rtp_header_extension_finder #(
   parameter int unsigned MAX_PACKET_BYTES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rtp_hef_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rtp_hef_pkg::rsp_type rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_data
);
   import rtp_hef_pkg::*;

   localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 2);
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET_BYTES);

   logic              in_valid_ff, in_valid_in;
   req_type           in_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [7:0]        target_ff, target_in;

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        first_ff, first_in;
   logic [15:0]       profile_ff, profile_in;
   logic [15:0]       length_ff, length_in;
   logic [PEND_W-1:0] pay_end_ff, pay_end_in;
   logic [7:0]        rem_ff, rem_in;
   logic [7:0]        id_ff, id_in;
   logic [11:0]       foff_ff, foff_in;
   logic [7:0]        flen_ff, flen_in;
   logic [3:0]        pstat_ff, pstat_in;

   logic              advance;
   logic              req_accept;
   logic [7:0]        b;
   logic [PEND_W-1:0] p_ext;
   logic [PEND_W-1:0] ext_off;
   logic [PEND_W-1:0] len_ext;
   logic [PEND_W-1:0] end_one;
   logic [PEND_W-1:0] end_two;
   logic [4:0]        size_one;
   logic              usable;
   logic [3:0]        status;

   // the input stage drains unless it holds a last byte and the result slot is full
   assign advance    = in_valid_ff && (!in_data_ff.last || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      target_in = (csr_valid && csr_ready) ? csr_data : target_ff;
      in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   end

   always_comb begin
      b        = in_data_ff.data_byte;
      p_ext    = PEND_W'(pos_ff);
      phase_in = phase_ff;
      pos_in   = (pos_ff <= MAX_POS) ? pos_ff + POS_W'(1) : pos_ff;
      first_in   = (pos_ff == '0) ? b : first_ff;
      profile_in = profile_ff;
      length_in  = length_ff;
      pay_end_in = pay_end_ff;
      rem_in     = rem_ff;
      id_in      = id_ff;
      foff_in    = foff_ff;
      flen_in    = flen_ff;
      pstat_in   = pstat_ff;
      ext_off  = PEND_W'(FIXED_HDR_BYTES) + PEND_W'({first_in[3:0], 2'b00});
      usable   = (first_in[7:6] == RTP_VERSION) && first_in[4];
      size_one = {1'b0, b[3:0]} + 5'd1;
      end_one  = p_ext + PEND_W'(1) + PEND_W'(size_one);
      end_two  = p_ext + PEND_W'(1) + PEND_W'(b);

      priority if (phase_ff == PH_HEAD) begin
         priority if (p_ext == PEND_W'(11) && !usable) begin
            phase_in = PH_DONE;
         end else if (p_ext >= ext_off && p_ext <= ext_off + PEND_W'(3)) begin
            if (p_ext < ext_off + PEND_W'(2)) begin
               profile_in = {profile_ff[7:0], b};
            end else begin
               length_in = {length_ff[7:0], b};
               if (p_ext == ext_off + PEND_W'(3)) begin
                  pay_end_in = ext_off + PEND_W'(4) + PEND_W'({length_in, 2'b00});
                  priority if (length_in == '0) begin
                     phase_in = PH_DONE;
                  end else if (profile_ff == PROFILE_ONE_BYTE) begin
                     phase_in = (target_ff >= 8'd15) ? PH_DONE : PH_ONE_HDR;
                  end else if ((profile_ff & PROFILE_TWO_MASK) == PROFILE_TWO_BYTE) begin
                     phase_in = PH_TWO_ID;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
            end
         end else begin
         end
      end else if (phase_ff != PH_DONE) begin
         if (p_ext >= pay_end_ff) begin
            phase_in = PH_DONE;
         end else begin
            unique case (phase_ff)
               PH_ONE_HDR: begin
                  if (b != 8'd0) begin
                     id_in = {4'b0000, b[7:4]};
                     priority if (b[7:4] == ID_RESERVED) begin
                        pstat_in = ST_ID15;
                        foff_in  = '0;
                        flen_in  = '0;
                        phase_in = PH_DONE;
                     end else if (end_one > pay_end_ff) begin
                        pstat_in = ST_ONE_ELEM_CUT;
                        foff_in  = '0;
                        flen_in  = '0;
                        phase_in = PH_DONE;
                     end else if (id_in == target_ff) begin
                        pstat_in = ST_FOUND;
                        foff_in  = p_ext[11:0] + 12'd1;
                        flen_in  = 8'(size_one);
                        phase_in = PH_DONE;
                     end else begin
                        rem_in   = 8'(size_one);
                        phase_in = PH_ONE_SKIP;
                     end
                  end
               end
               PH_ONE_SKIP, PH_TWO_SKIP: begin
                  rem_in = rem_ff - 8'd1;
                  if (rem_in == 8'd0) begin
                     phase_in = (phase_ff == PH_ONE_SKIP) ? PH_ONE_HDR : PH_TWO_ID;
                  end
               end
               PH_TWO_ID: begin
                  if (b != 8'd0) begin
                     if (p_ext + PEND_W'(1) >= pay_end_ff) begin
                        pstat_in = ST_TWO_LEN_CUT;
                        foff_in  = '0;
                        flen_in  = '0;
                        phase_in = PH_DONE;
                     end else begin
                        id_in    = b;
                        phase_in = PH_TWO_LEN;
                     end
                  end
               end
               PH_TWO_LEN: begin
                  priority if (end_two > pay_end_ff) begin
                     pstat_in = ST_TWO_ELEM_CUT;
                     foff_in  = '0;
                     flen_in  = '0;
                     phase_in = PH_DONE;
                  end else if (id_ff == target_ff) begin
                     pstat_in = ST_FOUND;
                     foff_in  = p_ext[11:0] + 12'd1;
                     flen_in  = b;
                     phase_in = PH_DONE;
                  end else if (b == 8'd0) begin
                     phase_in = PH_TWO_ID;
                  end else begin
                     rem_in   = b;
                     phase_in = PH_TWO_SKIP;
                  end
               end
               default: begin
               end
            endcase
         end
      end else begin
      end

      // status as seen with this byte included
      len_ext = PEND_W'(pos_in);
      priority if (target_ff == 8'd0) begin
         status = ST_ID_ZERO;
      end else if (pos_in > MAX_POS) begin
         status = ST_TOO_LONG;
      end else if (pos_in < POS_W'(12)) begin
         status = ST_SHORT_HDR;
      end else if (first_in[7:6] != RTP_VERSION) begin
         status = ST_BAD_VERSION;
      end else if (!first_in[4]) begin
         status = ST_NOT_FOUND;
      end else if (len_ext < ext_off + PEND_W'(4)) begin
         status = ST_EXT_HDR_CUT;
      end else if (len_ext < pay_end_in) begin
         status = ST_PAYLOAD_CUT;
      end else begin
         status = pstat_in;
      end

      rsp_data_in.status      = status;
      rsp_data_in.data_offset = (status == ST_FOUND) ? foff_in : '0;
      rsp_data_in.data_length = (status == ST_FOUND) ? flen_in : '0;

      priority if (!advance) begin
         phase_in   = phase_ff;
         pos_in     = pos_ff;
         first_in   = first_ff;
         profile_in = profile_ff;
         length_in  = length_ff;
         pay_end_in = pay_end_ff;
         rem_in     = rem_ff;
         id_in      = id_ff;
         foff_in    = foff_ff;
         flen_in    = flen_ff;
         pstat_in   = pstat_ff;
      end else if (in_data_ff.last) begin
         phase_in   = PH_HEAD;
         pos_in     = '0;
         first_in   = '0;
         profile_in = '0;
         length_in  = '0;
         pay_end_in = '0;
         rem_in     = '0;
         id_in      = '0;
         foff_in    = '0;
         flen_in    = '0;
         pstat_in   = ST_NOT_FOUND;
      end else begin
      end

      rsp_valid_in = (advance && in_data_ff.last) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= 8'd1;
         phase_ff     <= PH_HEAD;
         pos_ff       <= '0;
         first_ff     <= '0;
         profile_ff   <= '0;
         length_ff    <= '0;
         pay_end_ff   <= '0;
         rem_ff       <= '0;
         id_ff        <= '0;
         foff_ff      <= '0;
         flen_ff      <= '0;
         pstat_ff     <= ST_NOT_FOUND;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         target_ff    <= target_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         first_ff     <= first_in;
         profile_ff   <= profile_in;
         length_ff    <= length_in;
         pay_end_ff   <= pay_end_in;
         rem_ff       <= rem_in;
         id_ff        <= id_in;
         foff_ff      <= foff_in;
         flen_ff      <= flen_in;
         pstat_ff     <= pstat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_payload;
      end
      if (advance && in_data_ff.last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_data_unless_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_FOUND
      |-> rsp_payload.data_offset == '0 && rsp_payload.data_length == '0)
      else $error("offset or length set without a match");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= ST_TOO_LONG)
      else $error("status code out of range");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.last |=> pos_ff == '0 && phase_ff == PH_HEAD)
      else $error("packet state not cleared after last byte");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= MAX_POS + POS_W'(1))
      else $error("byte counter past saturation");

   a_empty_stage_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stalled while empty");
`endif

endmodule

// ===== verif/tb_rtp_header_extension_finder.sv =====
// ----------------------------------------------------------------------------
// RTP header extension finder testbench
// Streams RTP packets byte by byte into the finder. A packet-level predictor
// tracks each accepted byte and queues the expected result on the last byte.
// Every result transfer is checked against that queue. The target id is
// written for each phase, and the phases cycle through four idling patterns.
// ----------------------------------------------------------------------------
module tb_rtp_header_extension_finder;
   timeunit 1ns;
   timeprecision 1ps;

   import rtp_hef_pkg::*;

   localparam int MAX_BYTES   = 4096;
   localparam int QUIET_LIMIT = 3000;
   localparam int LONG_HOLD   = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = 8'd0;

   req_type     outgoing_bytes[$];
   rsp_type     expected_finds[$];
   logic [7:0]  pkt_bytes[$];
   int          planned_bytes = 0;
   int          fail_count = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_left = 0;
   logic        hold_request = 1'b0;
   rsp_type     want;

   // predictor state
   logic [7:0]  target_model = 8'd1;
   phase_type   parse_ph = PH_HEAD;
   logic [12:0] byte_pos;
   logic [3:0]  csrc_cnt;
   logic [15:0] ext_profile;
   logic [15:0] ext_words;
   logic [18:0] ext_end;
   logic [7:0]  elem_left;
   logic [7:0]  elem_id;
   logic [7:0]  first_octet;
   logic [11:0] hit_offset;
   logic [7:0]  hit_length;
   logic [3:0]  scan_status;

   rtp_header_extension_finder #(
      .MAX_PACKET_BYTES(MAX_BYTES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void restart_packet();
      parse_ph    = PH_HEAD;
      byte_pos    = '0;
      csrc_cnt    = '0;
      ext_profile = '0;
      ext_words   = '0;
      ext_end     = '0;
      elem_left   = '0;
      elem_id     = '0;
      hit_offset  = '0;
      hit_length  = '0;
      scan_status = ST_NOT_FOUND;
      first_octet = '0;
   endfunction

   function automatic void conclude_scan(logic [3:0] st, int off, int len);
      scan_status = st;
      hit_offset  = off[11:0];
      hit_length  = len[7:0];
      parse_ph    = PH_DONE;
   endfunction

   function automatic void header_octet(int p, logic [7:0] octet);
      int ext_off;
      bit usable;
      ext_off = 12 + 4 * csrc_cnt;
      usable  = (first_octet[7:6] == RTP_VERSION) && first_octet[4];
      if (p == FIXED_HDR_BYTES - 1 && !usable) begin
         parse_ph = PH_DONE;
         return;
      end
      if (p < ext_off || p > ext_off + 3) return;
      if (p < ext_off + 2) begin
         ext_profile = {ext_profile[7:0], octet};
         return;
      end
      ext_words = {ext_words[7:0], octet};
      if (p != ext_off + 3) return;
      ext_end = 19'(ext_off + 4 + 4 * ext_words);
      if (ext_end == ext_off + 4) begin
         parse_ph = PH_DONE;
      end else if (ext_profile == PROFILE_ONE_BYTE) begin
         // ids of 15 and above cannot appear in the one-byte form
         if (target_model >= ID_RESERVED) parse_ph = PH_DONE;
         else parse_ph = PH_ONE_HDR;
      end else if ((ext_profile & PROFILE_TWO_MASK) == PROFILE_TWO_BYTE) begin
         parse_ph = PH_TWO_ID;
      end else begin
         parse_ph = PH_DONE;
      end
   endfunction

   function automatic void scan_octet(int p, logic [7:0] octet);
      int size;
      if (p >= ext_end) begin
         parse_ph = PH_DONE;
         return;
      end
      case (parse_ph)
         PH_ONE_HDR: begin
            if (octet == 8'd0) return;
            elem_id = {4'h0, octet[7:4]};
            if (octet[7:4] == ID_RESERVED) begin
               conclude_scan(ST_ID15, 0, 0);
               return;
            end
            size = octet[3:0] + 1;
            if (p + 1 + size > ext_end) begin
               conclude_scan(ST_ONE_ELEM_CUT, 0, 0);
               return;
            end
            if (elem_id == target_model) begin
               conclude_scan(ST_FOUND, p + 1, size);
               return;
            end
            elem_left = size[7:0];
            parse_ph  = PH_ONE_SKIP;
         end
         PH_ONE_SKIP, PH_TWO_SKIP: begin
            elem_left = elem_left - 8'd1;
            if (elem_left == 8'd0) begin
               if (parse_ph == PH_ONE_SKIP) parse_ph = PH_ONE_HDR;
               else parse_ph = PH_TWO_ID;
            end
         end
         PH_TWO_ID: begin
            if (octet == 8'd0) return;
            if (p + 1 >= ext_end) begin
               conclude_scan(ST_TWO_LEN_CUT, 0, 0);
               return;
            end
            elem_id  = octet;
            parse_ph = PH_TWO_LEN;
         end
         PH_TWO_LEN: begin
            size = octet;
            if (p + 1 + size > ext_end) begin
               conclude_scan(ST_TWO_ELEM_CUT, 0, 0);
               return;
            end
            if (elem_id == target_model) begin
               conclude_scan(ST_FOUND, p + 1, size);
               return;
            end
            if (size == 0) begin
               parse_ph = PH_TWO_ID;
            end else begin
               elem_left = octet;
               parse_ph  = PH_TWO_SKIP;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void parse_packet_byte(req_type item);
      int         p;
      int         len;
      int         ext_off;
      logic [3:0] st;
      rsp_type    r;
      p = byte_pos;
      if (p == 0) begin
         first_octet = item.data_byte;
         csrc_cnt    = item.data_byte[3:0];
      end
      if (parse_ph == PH_HEAD) header_octet(p, item.data_byte);
      else if (parse_ph != PH_DONE) scan_octet(p, item.data_byte);
      // counter saturates one past the buffer size
      if (byte_pos <= MAX_BYTES) byte_pos = byte_pos + 13'd1;
      if (!item.last) return;
      len     = byte_pos;
      ext_off = 12 + 4 * csrc_cnt;
      if (target_model == 8'd0) st = ST_ID_ZERO;
      else if (len > MAX_BYTES) st = ST_TOO_LONG;
      else if (len < FIXED_HDR_BYTES) st = ST_SHORT_HDR;
      else if (first_octet[7:6] != RTP_VERSION) st = ST_BAD_VERSION;
      else if (!first_octet[4]) st = ST_NOT_FOUND;
      else if (len < ext_off + 4) st = ST_EXT_HDR_CUT;
      else if (len < ext_end) st = ST_PAYLOAD_CUT;
      else st = scan_status;
      r.status      = st;
      r.data_offset = (st == ST_FOUND) ? hit_offset : 12'd0;
      r.data_length = (st == ST_FOUND) ? hit_length : 8'd0;
      expected_finds.push_back(r);
      restart_packet();
   endfunction

   // ------------------------------------------------------------ packet build

   function automatic void put(logic [7:0] octet);
      pkt_bytes.push_back(octet);
   endfunction

   // first byte, rest of the fixed header and the CSRC list
   function automatic void rtp_head(logic [7:0] lead);
      put(lead);
      repeat (11 + 4 * lead[3:0]) put(8'($urandom));
   endfunction

   function automatic void ext_head(logic [15:0] prof, logic [15:0] words);
      put(prof[15:8]);
      put(prof[7:0]);
      put(words[15:8]);
      put(words[7:0]);
   endfunction

   function automatic void pad_to(int n);
      while (pkt_bytes.size() < n) put(8'($urandom));
   endfunction

   function automatic void send_packet();
      req_type item;
      foreach (pkt_bytes[i]) begin
         item.data_byte = pkt_bytes[i];
         item.last      = (i == pkt_bytes.size() - 1);
         outgoing_bytes.push_back(item);
      end
      planned_bytes += pkt_bytes.size();
      pkt_bytes.delete();
   endfunction

   function automatic void random_packet();
      int          kind;
      int          cc;
      int          words;
      int          body_from;
      int          room;
      int          hi;
      int          size;
      int          cut;
      bit          one_form;
      bit          fit;
      logic [7:0]  lead;
      logic [7:0]  id;
      logic [15:0] prof;
      logic [15:0] words_field;
      kind = $urandom_range(99);
      if (kind < 6) begin
         repeat ($urandom_range(1, 40)) put(8'($urandom));
         send_packet();
         return;
      end
      cc   = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1);
      lead = {RTP_VERSION, 1'($urandom), 1'b1, 4'(cc)};
      if (kind < 8) lead[7:6] = 2'($urandom_range(1));
      else if (kind < 10) lead[7:6] = 2'd3;
      else if (kind < 14) lead[4] = 1'b0;
      rtp_head(lead);
      one_form = $urandom_range(9) < 5;
      if ($urandom_range(19) == 0) prof = 16'($urandom);
      else if (one_form) prof = PROFILE_ONE_BYTE;
      else prof = PROFILE_TWO_BYTE | 16'($urandom_range(15));
      words       = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
      words_field = ($urandom_range(29) == 0) ? 16'($urandom) : 16'(words);
      ext_head(prof, words_field);
      body_from = pkt_bytes.size();
      while (pkt_bytes.size() < body_from + 4 * words) begin
         room = body_from + 4 * words - pkt_bytes.size();
         fit  = $urandom_range(19) != 0;
         if (target_model != 8'd0 && $urandom_range(2) == 0) id = target_model;
         else id = 8'($urandom_range(1, one_form ? 14 : 255));
         if ($urandom_range(4) == 0) begin
            put(8'h00);
         end else if (one_form) begin
            if ($urandom_range(29) == 0) id = {4'h0, ID_RESERVED};
            hi   = (room - 1 < 16) ? room - 1 : 16;
            size = (fit && room > 1) ? $urandom_range(1, hi) : $urandom_range(1, 16);
            put({id[3:0], 4'(size - 1)});
            repeat (size) put(8'($urandom));
         end else begin
            hi   = (room - 2 < 255) ? room - 2 : 255;
            size = (fit && room > 2) ? $urandom_range(0, hi) : $urandom_range(0, 40);
            put(id);
            put(8'(size));
            repeat (size) put(8'($urandom));
         end
      end
      while (pkt_bytes.size() > body_from + 4 * words) void'(pkt_bytes.pop_back());
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 8)) put(8'($urandom));
      if ($urandom_range(9) == 0) begin
         cut = $urandom_range(1, pkt_bytes.size());
         while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end
      send_packet();
   endfunction

   // ------------------------------------------------------------- handshakes

   task automatic write_target(logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      target_model  = value;
   endtask

   task automatic wait_drained();
      while (outgoing_bytes.size() != 0 || req_valid || expected_finds.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) parse_packet_byte(req_payload);
         if (!req_valid || req_ready) begin
            if (outgoing_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= outgoing_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result back-pressure, with an occasional long hold-off
   always @(posedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= stall_pct;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_finds.size() == 0) begin
            $error("result transfer with nothing expected: status %0d offset %0d length %0d",
                   rsp_payload.status, rsp_payload.data_offset, rsp_payload.data_length);
            fail_count++;
         end else begin
            want = expected_finds.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               fail_count++;
            end
            if (rsp_payload.data_offset !== want.data_offset) begin
               $error("data_offset: expected %0d, got %0d",
                      want.data_offset, rsp_payload.data_offset);
               fail_count++;
            end
            if (rsp_payload.data_length !== want.data_length) begin
               $error("data_length: expected %0d, got %0d",
                      want.data_length, rsp_payload.data_length);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      logic [7:0] phase_target[8];
      int         phase_end;
      restart_packet();
      phase_target = '{8'd5, 8'd3, 8'd255, 8'd14, 8'd0, 8'd15,
                       8'($urandom_range(1, 14)), 8'($urandom_range(16, 254))};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed packets, target id at its reset value
      rtp_head(8'h90); ext_head(PROFILE_ONE_BYTE, 16'd1);
      put(8'h10); put(8'hAA); put(8'h00); put(8'h00); send_packet();
      put(8'h90); send_packet();
      rtp_head(8'h90); void'(pkt_bytes.pop_back()); send_packet();
      rtp_head(8'h50); ext_head(PROFILE_ONE_BYTE, 16'd1); pad_to(20); send_packet();
      rtp_head(8'h80); pad_to(16); send_packet();
      rtp_head(8'h92); put(8'hBE); put(8'hDE); send_packet();
      rtp_head(8'h90); ext_head(PROFILE_ONE_BYTE, 16'd2); pad_to(20); send_packet();
      rtp_head(8'h90); ext_head(PROFILE_ONE_BYTE, 16'd1);
      put(8'hF3); put(8'h00); put(8'h00); put(8'h00); send_packet();
      rtp_head(8'h90); ext_head(PROFILE_ONE_BYTE, 16'd1);
      put(8'h00); put(8'h1F); put(8'h00); put(8'h00); send_packet();
      rtp_head(8'h90); ext_head(PROFILE_TWO_BYTE, 16'd1);
      put(8'h01); put(8'h02); put(8'hAB); put(8'hCD); send_packet();
      rtp_head(8'h90); ext_head(16'h100F, 16'd1);
      put(8'h00); put(8'h00); put(8'h00); put(8'h07); send_packet();
      rtp_head(8'h90); ext_head(16'h1003, 16'd1);
      put(8'h01); put(8'h05); put(8'h00); put(8'h00); send_packet();
      rtp_head(8'h90); ext_head(16'h1234, 16'd1);
      put(8'h01); put(8'h00); put(8'h00); put(8'h00); send_packet();
      rtp_head(8'h90); ext_head(PROFILE_ONE_BYTE, 16'd0); pad_to(24); send_packet();
      // full CSRC list, one element skipped before the match
      rtp_head(8'h9F); ext_head(PROFILE_ONE_BYTE, 16'd2);
      put(8'h21); put(8'hFF); put(8'h00); put(8'h10); put(8'h5A);
      put(8'h00); put(8'h00); put(8'h00); send_packet();
      // empty two-byte element, a skipped one, then a zero-length match
      rtp_head(8'hB0); ext_head(PROFILE_TWO_BYTE, 16'd2);
      put(8'h05); put(8'h00); put(8'h07); put(8'h01); put(8'hFF);
      put(8'h01); put(8'h00); put(8'h00); send_packet();
      // no match, bytes after the extension
      rtp_head(8'h90); ext_head(PROFILE_ONE_BYTE, 16'd1);
      put(8'h20); put(8'hAA); put(8'h00); put(8'h00); pad_to(40); send_packet();
      // too long, running the byte counter into saturation
      rtp_head(8'h90); ext_head(PROFILE_ONE_BYTE, 16'd1);
      put(8'h10); put(8'h55); put(8'h00); put(8'h00); pad_to(MAX_BYTES + 2); send_packet();
      wait_drained();

      // random phases, each writing its target id and using one of four idling patterns
      for (int ph = 0; ph < 8; ph++) begin
         write_target(phase_target[ph]);
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 73;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 73;
            end
            default: begin
               send_idle_pct = 14;
               stall_pct     = 14;
            end
         endcase
         // long hold-off while bytes keep coming, to back up the input
         if (ph == 0) hold_request = 1'b1;
         phase_end = planned_bytes + 260;
         while (planned_bytes < phase_end) random_packet();
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
